>>> src/bed_pkg.sv
// Shared types, character codes and helper functions for the escape decoder.
package bed_pkg;

   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_QUESTION  = 8'h3f;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_UPPER_X   = 8'h58;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6e;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_V   = 8'h76;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CASE_MASK    = 8'hdf;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_HEX  = 4'b0100,
      MODE_OCT  = 4'b1000
   } mode_type;

   // Results of one input item, first result in data[0].
   typedef struct packed {
      logic [MaxResults-1:0][7:0] data;
      logic [CountWidth-1:0]      count;
      logic                       last;
   } result_set_type;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic                  load_ok;
   } buf_status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } simple_esc_type;

   function automatic logic is_hex(input logic [7:0] b);
      logic [7:0] u;
      u = b & CASE_MASK;
      return (b >= CH_ZERO && b <= CH_NINE) || (u >= CH_UPPER_A && u <= CH_UPPER_F);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] v;
      if (b >= CH_ZERO && b <= CH_NINE) v = b - CH_ZERO;
      else v = (b & CASE_MASK) - CH_UPPER_A + 8'd10;
      return v[3:0];
   endfunction

   function automatic logic is_octal(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_SEVEN;
   endfunction

   function automatic logic [2:0] octal_digit(input logic [7:0] b);
      logic [7:0] v;
      v = b - CH_ZERO;
      return v[2:0];
   endfunction

   function automatic simple_esc_type simple_escape(input logic [7:0] b);
      simple_esc_type r;
      r.valid = 1'b1;
      unique case (b)
         CH_LOWER_A:   r.value = 8'h07;
         CH_LOWER_B:   r.value = 8'h08;
         CH_LOWER_F:   r.value = 8'h0c;
         CH_LOWER_N:   r.value = 8'h0a;
         CH_LOWER_R:   r.value = 8'h0d;
         CH_LOWER_T:   r.value = 8'h09;
         CH_LOWER_V:   r.value = 8'h0b;
         CH_BACKSLASH: r.value = CH_BACKSLASH;
         CH_QUESTION:  r.value = CH_QUESTION;
         CH_SQUOTE:    r.value = CH_SQUOTE;
         CH_DQUOTE:    r.value = CH_DQUOTE;
         default: begin
            r.valid = 1'b0;
            r.value = b;
         end
      endcase
      return r;
   endfunction

endpackage

>>> src/bed_req_if.sv
// Input channel: raw byte with end-of-string flag.
interface bed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> src/bed_rsp_if.sv
// Result channel: decoded byte with end-of-string flag.
interface bed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> src/backslash_escape_decode_top.sv
// Top level of the C-style backslash escape decoder.
//
// req_if carries raw bytes of an encoded string, in_last marking the final
// byte. rsp_if carries decoded bytes; out_last marks the final byte of each
// string, and every string that ends produces at least one result byte.
// An accepted item is decoded in the same cycle into zero to four result
// bytes, which appear on rsp_if from the next cycle on. Results drain one
// per cycle from a four-entry buffer while the receiver takes them. An item
// that yields at most one byte leaves the buffer free for the next, so such
// items flow at one per cycle when nothing stalls; a flushed escape yielding
// more bytes holds the buffer and req_if.ready low until its last is taken.
// When the receiver stalls, the buffered results hold and req_if.ready stays
// low for as long as any result is waiting untaken.
// Synchronous reset empties the buffer and returns the decoder to the idle
// state with no escape pending; no clearing pass is needed.
module backslash_escape_decode_top (
   input logic      clock,
   input logic      reset,
   bed_req_if.sink  req_if,
   bed_rsp_if.source rsp_if
);
   import bed_pkg::*;

   result_set_type res;
   buf_status_type status;
   logic           accept;
   logic           take;

   assign take          = rsp_if.valid && rsp_if.ready;
   assign req_if.ready  = status.load_ok;
   assign accept        = req_if.valid && status.load_ok;

   bed_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_if.in_byte),
      .in_last (req_if.in_last),
      .res     (res)
   );

   bed_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res       (res),
      .take      (take),
      .out_byte  (rsp_if.out_byte),
      .out_last  (rsp_if.out_last),
      .out_valid (rsp_if.valid),
      .status    (status)
   );

   a_last_yields_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.in_last |-> res.count != '0)
      else $error("string end produced no result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept && res.count != '0 |=> rsp_if.valid)
      else $error("loaded results not presented");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.out_last |-> status.count == CountWidth'(1))
      else $error("end flag on a non-final result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= CountWidth'(MaxResults))
      else $error("result buffer overfilled");

endmodule

>>> src/bed_decoder.sv
// Escape state registers and the per-item decode logic.
module bed_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output bed_pkg::result_set_type res
);
   import bed_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;
   logic [8:0] octal_ff, octal_in;

   simple_esc_type        esc;
   logic                  b_hex;
   logic                  b_oct;
   logic                  starts_esc;
   logic [1:0]            oct_count;
   logic [8:0]            oct_next;
   logic [CountWidth-1:0] n;

   assign esc        = simple_escape(in_byte);
   assign b_hex      = is_hex(in_byte);
   assign b_oct      = is_octal(in_byte);
   assign starts_esc = (in_byte == CH_BACKSLASH) && !in_last;
   assign oct_count  = count_ff + 2'd1;
   assign oct_next   = {octal_ff[5:0], octal_digit(in_byte)};

   always_comb begin
      mode_in  = mode_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      count_in = count_ff;
      octal_in = octal_ff;
      res.data = '0;
      n        = '0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (starts_esc) begin
               mode_in = MODE_ESC;
            end else begin
               res.data[0] = in_byte;
               n = 3'd1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_IDLE;
            if (esc.valid) begin
               res.data[0] = esc.value;
               n = 3'd1;
            end else if (in_byte == CH_LOWER_X || in_byte == CH_UPPER_X) begin
               if (in_last) begin
                  res.data[0] = CH_BACKSLASH;
                  res.data[1] = in_byte;
                  n = 3'd2;
               end else begin
                  mode_in  = MODE_HEX;
                  held0_in = in_byte;
                  count_in = 2'd0;
               end
            end else if (b_oct) begin
               if (in_last) begin
                  res.data[0] = {5'd0, octal_digit(in_byte)};
                  n = 3'd1;
               end else begin
                  mode_in  = MODE_OCT;
                  octal_in = {6'd0, octal_digit(in_byte)};
                  count_in = 2'd1;
               end
            end else begin
               res.data[0] = CH_BACKSLASH;
               res.data[1] = in_byte;
               n = 3'd2;
            end
         end
         MODE_HEX: begin
            if (count_ff == 2'd0) begin
               if (b_hex && !in_last) begin
                  held1_in = in_byte;
                  count_in = 2'd1;
               end else begin
                  // Cut short: copy backslash and x raw, redecode this byte
                  res.data[0] = CH_BACKSLASH;
                  res.data[1] = held0_ff;
                  n = 3'd2;
                  mode_in = starts_esc ? MODE_ESC : MODE_IDLE;
                  if (!starts_esc) begin
                     res.data[2] = in_byte;
                     n = 3'd3;
                  end
               end
            end else if (b_hex) begin
               res.data[0] = {hex_nibble(held1_ff), hex_nibble(in_byte)};
               n = 3'd1;
               mode_in = MODE_IDLE;
            end else begin
               res.data[0] = CH_BACKSLASH;
               res.data[1] = held0_ff;
               res.data[2] = held1_ff;
               n = 3'd3;
               mode_in = starts_esc ? MODE_ESC : MODE_IDLE;
               if (!starts_esc) begin
                  res.data[3] = in_byte;
                  n = 3'd4;
               end
            end
         end
         MODE_OCT: begin
            if (b_oct) begin
               octal_in = oct_next;
               count_in = oct_count;
               if (oct_count == 2'd3 || in_last) begin
                  res.data[0] = oct_next[7:0];
                  n = 3'd1;
                  mode_in = MODE_IDLE;
               end
            end else begin
               res.data[0] = octal_ff[7:0];
               n = 3'd1;
               mode_in = starts_esc ? MODE_ESC : MODE_IDLE;
               if (!starts_esc) begin
                  res.data[1] = in_byte;
                  n = 3'd2;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
      // End of string flushes any pending escape
      if (in_last) mode_in = MODE_IDLE;
      res.count = n;
      res.last  = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= 2'd0;
         octal_ff <= 9'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         octal_ff <= octal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

>>> src/bed_out_buffer.sv
// Result buffer: holds one item's results and drains them one per cycle while the receiver takes them.
module bed_out_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  bed_pkg::result_set_type res,
   input  logic                    take,
   output logic [7:0]              out_byte,
   output logic                    out_last,
   output logic                    out_valid,
   output bed_pkg::buf_status_type status
);
   import bed_pkg::*;

   logic [MaxResults-1:0][7:0] data_ff, data_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   logic                       last_ff, last_in;

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         data_in  = res.data;
         count_in = res.count;
         last_in  = res.last;
      end else if (take) begin
         // Advance the queue by one entry
         for (int i = 0; i < MaxResults - 1; i++) data_in[i] = data_ff[i+1];
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign out_valid      = count_ff != '0;
   assign out_byte       = data_ff[0];
   assign out_last       = last_ff && (count_ff == CountWidth'(1));
   assign status.count   = count_ff;
   assign status.load_ok = (count_ff == '0) || ((count_ff == CountWidth'(1)) && take);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the backslash escape decoder top level.
module tb_top;
   import bed_pkg::*;

   localparam logic [7:0] CH_EIGHT   = 8'h38;
   localparam logic [7:0] CH_LOWER_G = 8'h67;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_type;

   logic clock;
   logic reset;

   bed_req_if req_if ();
   bed_rsp_if rsp_if ();

   backslash_escape_decode_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // decoder state kept by the predictor
   mode_type   dec_mode;
   logic [7:0] hex_prefix;
   logic [7:0] hex_first;
   logic [1:0] digit_count;
   logic [8:0] octal_acc;
   logic [7:0] step_data [4];
   int         step_count;

   decoded_type expected_bytes [$];
   logic [7:0]  string_bytes [$];

   int  mismatch_count = 0;
   int  bytes_sent     = 0;
   int  strings_sent   = 0;
   int  bytes_checked  = 0;
   int  hold_off_cycles = 0;
   int  sink_stall_left = 0;
   bit  src_gaps_on  = 1'b1;
   bit  sink_gaps_on = 1'b1;

   logic [7:0] esc_letters [11] = '{CH_LOWER_A, CH_LOWER_B, CH_LOWER_F, CH_LOWER_N,
                                    CH_LOWER_R, CH_LOWER_T, CH_LOWER_V, CH_BACKSLASH,
                                    CH_QUESTION, CH_SQUOTE, CH_DQUOTE};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("tb_top: errors");
      $finish;
   end

   function automatic int hex_val(input logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return b - CH_ZERO;
      if (b >= CH_LOWER_A && b <= CH_LOWER_F) return b - CH_LOWER_A + 10;
      if (b >= CH_UPPER_A && b <= CH_UPPER_F) return b - CH_UPPER_A + 10;
      return -1;
   endfunction

   function automatic bit octal_char(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_SEVEN;
   endfunction

   function automatic int control_code(input logic [7:0] b);
      case (b)
         CH_LOWER_A: return 8'h07;
         CH_LOWER_B: return 8'h08;
         CH_LOWER_F: return 8'h0c;
         CH_LOWER_N: return 8'h0a;
         CH_LOWER_R: return 8'h0d;
         CH_LOWER_T: return 8'h09;
         CH_LOWER_V: return 8'h0b;
         CH_BACKSLASH, CH_QUESTION, CH_SQUOTE, CH_DQUOTE: return b;
         default: return -1;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input int n, input bit upper);
      if (n < 10) return 8'(CH_ZERO + n);
      return 8'((upper ? CH_UPPER_A : CH_LOWER_A) + n - 10);
   endfunction

   task automatic put(input logic [7:0] b);
      if (step_count < MaxResults) begin
         step_data[step_count] = b;
         step_count++;
      end
   endtask

   task automatic decode_fresh(input logic [7:0] b, input logic last);
      dec_mode = MODE_IDLE;
      if (b == CH_BACKSLASH && !last) dec_mode = MODE_ESC;
      else put(b);
   endtask

   // Work out the decoded bytes of one accepted item and queue them.
   task automatic decode_step(input logic [7:0] b, input logic last);
      int s;
      int h;
      int hi;
      decoded_type item;
      step_count = 0;
      case (dec_mode)
         MODE_IDLE: decode_fresh(b, last);
         MODE_ESC: begin
            dec_mode = MODE_IDLE;
            s = control_code(b);
            if (s >= 0) begin
               put(8'(s));
            end else if (b == CH_LOWER_X || b == CH_UPPER_X) begin
               if (last) begin
                  put(CH_BACKSLASH);
                  put(b);
               end else begin
                  dec_mode = MODE_HEX;
                  hex_prefix = b;
                  digit_count = 2'd0;
               end
            end else if (octal_char(b)) begin
               if (last) begin
                  put(b - CH_ZERO);
               end else begin
                  dec_mode = MODE_OCT;
                  octal_acc = 9'(b - CH_ZERO);
                  digit_count = 2'd1;
               end
            end else begin
               put(CH_BACKSLASH);
               put(b);
            end
         end
         MODE_HEX: begin
            h = hex_val(b);
            if (digit_count == 2'd0) begin
               if (h >= 0 && !last) begin
                  hex_first = b;
                  digit_count = 2'd1;
               end else begin
                  put(CH_BACKSLASH);
                  put(hex_prefix);
                  decode_fresh(b, last);
               end
            end else if (h >= 0) begin
               hi = hex_val(hex_first);
               put(8'(hi * 16 + h));
               dec_mode = MODE_IDLE;
            end else begin
               put(CH_BACKSLASH);
               put(hex_prefix);
               put(hex_first);
               decode_fresh(b, last);
            end
         end
         default: begin
            if (octal_char(b)) begin
               octal_acc = {octal_acc[5:0], 3'(b - CH_ZERO)};
               digit_count = digit_count + 2'd1;
               if (digit_count == 2'd3 || last) begin
                  put(octal_acc[7:0]);
                  dec_mode = MODE_IDLE;
               end
            end else begin
               put(octal_acc[7:0]);
               decode_fresh(b, last);
            end
         end
      endcase
      if (last) dec_mode = MODE_IDLE;
      for (int i = 0; i < step_count; i++) begin
         item.data = step_data[i];
         item.last = last && (i == step_count - 1);
         expected_bytes.push_back(item);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_cycles--;
         end else if (sink_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            sink_stall_left--;
         end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            sink_stall_left = $urandom_range(0, 9);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual byte %02h last %0b",
                     $time, rsp_if.out_byte, rsp_if.out_last);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_if.out_byte !== want.data) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.data, rsp_if.out_byte);
               mismatch_count++;
            end
            if (rsp_if.out_last !== want.last) begin
               $display("%0t: out_last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_if.out_last);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one item and hold it until accepted; valid stays high afterwards
   // unless a gap follows, so the caller must send again in the same step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      decode_step(b, last);
      bytes_sent++;
      if (src_gaps_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_string();
      for (int i = 0; i < string_bytes.size(); i++)
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
      string_bytes.delete();
      strings_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic add_escape(input logic [7:0] b);
      string_bytes.push_back(CH_BACKSLASH);
      string_bytes.push_back(b);
   endtask

   // Append one piece of an encoded string: raw bytes, well-formed escapes or broken ones.
   task automatic add_fragment();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1: begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BACKSLASH) b = CH_UPPER_A;
            string_bytes.push_back(b);
         end
         2, 3: add_escape(esc_letters[$urandom_range(0, 10)]);
         4, 5: begin
            add_escape($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            string_bytes.push_back(hex_char($urandom_range(0, 15),
                                            1'($urandom_range(0, 1))));
            string_bytes.push_back(hex_char($urandom_range(0, 15),
                                            1'($urandom_range(0, 1))));
         end
         6: begin
            string_bytes.push_back(CH_BACKSLASH);
            repeat ($urandom_range(1, 3))
               string_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
         end
         7: begin
            // hex escape cut short by a stray byte
            add_escape($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            if ($urandom_range(0, 1))
               string_bytes.push_back(hex_char($urandom_range(0, 15),
                                               1'($urandom_range(0, 1))));
            if ($urandom_range(0, 2) != 0)
               string_bytes.push_back(8'($urandom_range(0, 255)));
         end
         8: add_escape(8'($urandom_range(0, 255)));
         default: begin
            b = ($urandom_range(0, 3) == 0) ? CH_BACKSLASH : 8'($urandom_range(0, 255));
            string_bytes.push_back(b);
         end
      endcase
   endtask

   task automatic send_random_strings(input int target);
      int stop_at;
      stop_at = bytes_sent + target;
      while (bytes_sent < stop_at) begin
         repeat ($urandom_range(1, 6)) add_fragment();
         send_string();
      end
   endtask

   task automatic test_directed();
      string_bytes.push_back(8'h00);
      string_bytes.push_back(8'hff);
      send_string();
      foreach (esc_letters[i]) add_escape(esc_letters[i]);
      send_string();
      // full hex escape, then three octal digits ending the string
      add_escape(CH_LOWER_X);
      string_bytes.push_back(CH_LOWER_A);
      string_bytes.push_back(CH_UPPER_F);
      add_escape(CH_SEVEN);
      string_bytes.push_back(CH_SEVEN);
      string_bytes.push_back(CH_SEVEN);
      send_string();
      add_escape(CH_UPPER_X);
      string_bytes.push_back(CH_LOWER_G);
      send_string();
      add_escape(CH_ZERO + 8'd1);
      string_bytes.push_back(CH_EIGHT);
      send_string();
      string_bytes.push_back(CH_BACKSLASH);
      send_string();
   endtask

   task automatic test_random_streams();
      for (int k = 0; k < 8; k++) begin
         src_gaps_on  = $urandom_range(0, 3) != 0;
         sink_gaps_on = $urandom_range(0, 3) != 0;
         send_random_strings(40);
      end
      src_gaps_on  = 1'b1;
      sink_gaps_on = 1'b1;
   endtask

   task automatic test_receiver_hold_off();
      src_gaps_on = 1'b0;
      hold_off_cycles = 150;
      send_random_strings(25);
      wait_drained();
      src_gaps_on = 1'b1;
   endtask

   task automatic test_full_rate();
      src_gaps_on  = 1'b0;
      sink_gaps_on = 1'b0;
      send_random_strings(60);
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.in_last <= 1'b0;
      dec_mode    = MODE_IDLE;
      digit_count = 2'd0;
      octal_acc   = 9'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_streams();
      test_receiver_hold_off();
      test_full_rate();

      wait_drained();
      repeat (6) @(posedge clock);
      $display("summary: %0d bytes in %0d strings sent, %0d decoded bytes checked",
               bytes_sent, strings_sent, bytes_checked);
      $display("summary: escapes, cut-short sequences, receiver hold-off, full rate");
      if (mismatch_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
